### rtl/ita_pkg.sv
// Package for the integer to ASCII formatter.
// Conversion codes, fixed field widths and the digit glyph function.
// No dependencies.
package ita_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;

    typedef enum logic [1:0] {
        CMD_SDEC = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_CHAR = 2'd3
    } cmd_t;

    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    // load request from the sequencer to the character emitter
    typedef struct packed {
        logic              load;
        logic              has_lead;
        logic [CHAR_W-1:0] lead_char;
        logic              lead_last;
    } emit_ctrl_t;

    // 0..f to lowercase ASCII
    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] g;
        if (d < 4'd10)
        begin
            g = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            g = CHAR_LOWER_A + {4'd0, d} - 8'd10;
        end
        return g;
    endfunction

endpackage

### rtl/ita_if.sv
// Channel interfaces for the integer to ASCII formatter.
// Command word channel and character word channel; uses ita_pkg widths.
interface ita_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [ita_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface ita_char_if;
    logic                          valid;
    logic                          ready;
    logic [ita_pkg::CHAR_W-1:0]    character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

### rtl/ita_dabble.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Uses no package items; driven by the formatter sequencer.
module ita_dabble #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned DIGITS     = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   mag,
    output logic                    busy,
    output logic [DIGITS*4-1:0]     bcd
);

    localparam int unsigned DW = DIGITS * 4;
    localparam int unsigned CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]         bcd_reg, bcd_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DW-1:0]         adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                         : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CW'(VALUE_BITS);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next = {adj[DW-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = (cnt_reg != '0);
    assign bcd  = bcd_reg;

endmodule

### rtl/ita_emit.sv
// Character emitter: strips leading zeros; one character a cycle unless stalled.
// Uses ita_pkg (emit_ctrl_t, glyph) and ita_char_if; holds the output register.
module ita_emit #(
    parameter int unsigned DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ita_pkg::emit_ctrl_t   ctrl,
    input  logic [DIGITS*4-1:0]   digits,
    output logic                  busy,
    ita_char_if.source            txt
);

    localparam int unsigned DW = DIGITS * 4;
    localparam int unsigned LW = $clog2(DIGITS + 1);

    typedef enum logic [1:0] {
        E_IDLE,
        E_LEAD,
        E_SKIP,
        E_DIGITS
    } phase_t;

    phase_t                       phase_reg;
    logic [DW-1:0]                digits_reg;
    logic [LW-1:0]                left_reg;
    logic [ita_pkg::CHAR_W-1:0]   lead_char_reg;
    logic                         lead_last_reg;
    logic                         valid_reg;
    logic [ita_pkg::CHAR_W-1:0]   char_reg;
    logic                         last_reg;
    logic                         slot_free;
    logic                         emit_now;
    logic [3:0]                   top_digit;

    assign slot_free = !valid_reg || txt.ready;
    assign top_digit = digits_reg[DW-1 -: 4];
    // a new character enters the output register this cycle
    assign emit_now  = slot_free && (phase_reg == E_LEAD || phase_reg == E_DIGITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= E_IDLE;
            valid_reg     <= 1'b0;
            digits_reg    <= '0;
            left_reg      <= '0;
            lead_char_reg <= '0;
            lead_last_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit_now)
            begin
                valid_reg <= 1'b1;
            end
            else if (txt.ready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (phase_reg)
                E_IDLE:
                begin
                    if (ctrl.load)
                    begin
                        digits_reg    <= digits;
                        left_reg      <= LW'(DIGITS);
                        lead_char_reg <= ctrl.lead_char;
                        lead_last_reg <= ctrl.lead_last;
                        phase_reg     <= ctrl.has_lead ? E_LEAD : E_SKIP;
                    end
                end
                E_LEAD:
                begin
                    if (slot_free)
                    begin
                        char_reg  <= lead_char_reg;
                        last_reg  <= lead_last_reg;
                        phase_reg <= lead_last_reg ? E_IDLE : E_SKIP;
                    end
                end
                E_SKIP:
                begin
                    // keep at least one digit so zero prints as "0"
                    if (top_digit == 4'd0 && left_reg != LW'(1))
                    begin
                        digits_reg <= {digits_reg[DW-5:0], 4'd0};
                        left_reg   <= left_reg - LW'(1);
                    end
                    else
                    begin
                        phase_reg <= E_DIGITS;
                    end
                end
                E_DIGITS:
                begin
                    if (slot_free)
                    begin
                        char_reg   <= ita_pkg::glyph(top_digit);
                        last_reg   <= (left_reg == LW'(1));
                        digits_reg <= {digits_reg[DW-5:0], 4'd0};
                        left_reg   <= left_reg - LW'(1);
                        if (left_reg == LW'(1))
                        begin
                            phase_reg <= E_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign busy          = (phase_reg != E_IDLE);
    assign txt.valid     = valid_reg;
    assign txt.character = char_reg;
    assign txt.last      = last_reg;

endmodule

### rtl/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter, top level: command sequencer.
// Uses ita_pkg, ita_if, ita_dabble and ita_emit.
//
// Usage: a word on cmd carries a conversion command (signed decimal,
// unsigned decimal, lowercase hex, single character) and a 32-bit value.
// The text comes out on txt as one character word per handshake, most
// significant first, with last set on the final character of the run.
// cmd.ready is high only while the sequencer is idle; one command is
// worked on at a time.
// Decimal commands run the shift-and-add-3 unit over all VALUE_BITS bits,
// then load the emitter, which drops leading zero digits one per cycle
// and sends one character per cycle while txt is ready. Hex and
// character commands load the emitter on accept. The BCD unit is the
// limit on decimal throughput.
// Reset clears the sequencer, the emitter state, the output valid and
// the BCD unit's bit counter; the BCD data registers have no reset.
// A stall on txt holds the current character, and the emitter sends no
// further character until it is taken; the next command can be accepted
// once the final character is in the output register, even if it has
// not been taken yet.
module integer_to_ascii_formatter_top #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ita_cmd_if.sink      cmd,
    ita_char_if.source   txt
);

    localparam int unsigned DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int unsigned DW     = DIGITS * 4;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_OUT
    } state_t;

    state_t                 state_reg;
    logic                   neg_reg;
    logic                   accept;
    ita_pkg::cmd_t          cmd_code;
    logic [VALUE_BITS-1:0]  v;
    logic                   neg;
    logic [VALUE_BITS-1:0]  mag;
    logic                   dab_start;
    logic                   dab_busy;
    logic [DW-1:0]          bcd;
    logic                   emit_busy;
    ita_pkg::emit_ctrl_t    ctrl;
    logic [DW-1:0]          digits;

    assign accept   = cmd.valid && cmd.ready;
    assign cmd_code = ita_pkg::cmd_t'(cmd.command);
    assign v        = VALUE_BITS'(cmd.value);
    assign neg      = (cmd_code == ita_pkg::CMD_SDEC) && v[VALUE_BITS-1];
    assign mag      = neg ? (~v + VALUE_BITS'(1)) : v;
    assign cmd.ready = (state_reg == T_IDLE);

    always_comb
    begin
        dab_start      = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.has_lead  = 1'b0;
        ctrl.lead_char = ita_pkg::CHAR_MINUS;
        ctrl.lead_last = 1'b0;
        digits         = bcd;
        if (state_reg == T_CONV)
        begin
            ctrl.load     = !dab_busy;
            ctrl.has_lead = neg_reg;
        end
        else if (accept)
        begin
            unique case (cmd_code)
                ita_pkg::CMD_SDEC,
                ita_pkg::CMD_UDEC:
                begin
                    dab_start = 1'b1;
                end
                ita_pkg::CMD_HEX:
                begin
                    ctrl.load = 1'b1;
                    digits    = DW'(mag);
                end
                ita_pkg::CMD_CHAR:
                begin
                    ctrl.load      = 1'b1;
                    ctrl.has_lead  = 1'b1;
                    ctrl.lead_char = cmd.value[ita_pkg::CHAR_W-1:0];
                    ctrl.lead_last = 1'b1;
                end
                default:
                begin
                    dab_start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        neg_reg   <= neg;
                        state_reg <= dab_start ? T_CONV : T_OUT;
                    end
                end
                T_CONV:
                begin
                    if (!dab_busy)
                    begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    // emitter goes busy the cycle after its load
                    if (!emit_busy)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    ita_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag),
        .busy  (dab_busy),
        .bcd   (bcd)
    );

    ita_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .digits (digits),
        .busy   (emit_busy),
        .txt    (txt)
    );

endmodule
